// ===== rtl/core/pdbv_pkg.sv =====
// ----------------------------------------------------------------------------
// pdbv_pkg
// Shared widths, constants, command/status types and the CORDIC arctangent
// table for the pose difference body velocity block.
// ----------------------------------------------------------------------------
package pdbv_pkg;

   // field widths
   localparam int PosW    = 32;
   localparam int HeadW   = 19;
   localparam int TimeW   = 48;
   localparam int VelW    = 32;

   // internal widths
   localparam int DiffW   = 33;   // position difference
   localparam int AngW    = 20;   // heading arithmetic
   localparam int NumW    = 53;   // scaled dividend / quotient
   localparam int RemW    = 49;   // divider remainder
   localparam int WvW     = 41;   // world velocity after clipping
   localparam int XyW     = 34;   // cordic x and y
   localparam int ZW      = 32;   // cordic angle accumulator
   localparam int TrigW   = 24;   // cos and sin, Q.20
   localparam int AccW    = 64;   // rotation accumulator, Q.36
   localparam int RndW    = 44;   // rounded rotation result
   localparam int CntW    = 6;

   localparam int DivSteps = 53;
   localparam int CorSteps = 20;
   localparam int MacSteps = 6;

   // angle constants in 2^-16 rad
   localparam logic signed [AngW-1:0] PI_Q16      = 20'sd205887;
   localparam logic signed [AngW-1:0] TWO_PI_Q16  = 20'sd411775;
   localparam logic signed [AngW-1:0] HALF_PI_Q16 = 20'sd102944;

   localparam logic signed [TimeW:0]  MIN_DT_US   = 49'sd100;
   localparam logic [19:0]            US_PER_S    = 20'd1000000;
   localparam logic signed [XyW-1:0]  CORDIC_GAIN = 34'sd652032874;

   // clipping limits on quotient magnitudes
   localparam logic [NumW-1:0] WV_LIM  = 53'h100_0000_0000;
   localparam logic [NumW-1:0] YAW_LIM = 53'h8000_0000;

   localparam logic signed [RndW-1:0] OUT_MAX = 44'sh0_7FFF_FFFF;
   localparam logic signed [RndW-1:0] OUT_MIN = -44'sh0_8000_0000;

   // divider operand select
   typedef enum logic [1:0] {
      SEL_X,
      SEL_Y,
      SEL_W
   } pdbv_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic         capture;
      logic         div_load;
      logic         div_step;
      logic         div_store;
      pdbv_sel_type div_sel;
      logic         cor_step;
      logic [4:0]   cor_idx;
      logic         mac_step;
      logic [2:0]   mac_idx;
      logic         out_load;
   } pdbv_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic derive;
   } pdbv_sts_type;

   // arctangent of 2^-i in Q24 radians
   function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:    v = 32'sd13176795;
         5'd1:    v = 32'sd7778716;
         5'd2:    v = 32'sd4110060;
         5'd3:    v = 32'sd2086331;
         5'd4:    v = 32'sd1047214;
         5'd5:    v = 32'sd524117;
         5'd6:    v = 32'sd262123;
         5'd7:    v = 32'sd131069;
         5'd8:    v = 32'sd65536;
         5'd9:    v = 32'sd32768;
         5'd10:   v = 32'sd16384;
         5'd11:   v = 32'sd8192;
         5'd12:   v = 32'sd4096;
         5'd13:   v = 32'sd2048;
         5'd14:   v = 32'sd1024;
         5'd15:   v = 32'sd512;
         5'd16:   v = 32'sd256;
         5'd17:   v = 32'sd128;
         5'd18:   v = 32'sd64;
         5'd19:   v = 32'sd32;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/pose_difference_body_velocity.sv =====
// ----------------------------------------------------------------------------
// pose_difference_body_velocity
// Robot-frame velocity from successive timestamped planar poses, by finite
// difference, division by the time gap and cordic rotation.
// ----------------------------------------------------------------------------
// channel   direction  handshake        payload
// req       in         valid / stall    pose, timestamp, supplied velocity
// rsp       out        valid / stall    body velocity, yaw rate, flags
// csr       in         valid / ready    derive_enable
//
// a pass-through request goes from acceptance via the decision state to the
// done state, which loads the response register; a derived request passes a
// decision state, the one-bit-a-cycle divider run three times (with load
// and store), 20 cordic steps, 6 rotation steps on one shared multiplier and
// the load. one request at a time; the next is taken while a response waits.
// reset is synchronous: no previous pose, derive_enable set.
// a stalled response holds the response register and blocks completion only.
// ----------------------------------------------------------------------------
module pose_difference_body_velocity (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [18:0] req_heading,
   input  logic [47:0]        req_time_us,
   input  logic               req_has_vel,
   input  logic signed [31:0] req_vx_in,
   input  logic signed [31:0] req_vy_in,
   input  logic signed [31:0] req_wz_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_vel_fwd,
   output logic signed [31:0] rsp_vel_lat,
   output logic signed [31:0] rsp_yaw_rate,
   output logic               rsp_vel_valid,
   output logic               rsp_saturated
);

   pdbv_pkg::pdbv_cmd_type cmd;
   pdbv_pkg::pdbv_sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer
   pdbv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and storage
   pdbv_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_data      (csr_data),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_heading   (req_heading),
      .req_time_us   (req_time_us),
      .req_has_vel   (req_has_vel),
      .req_vx_in     (req_vx_in),
      .req_vy_in     (req_vy_in),
      .req_wz_in     (req_wz_in),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_vel_fwd   (rsp_vel_fwd),
      .rsp_vel_lat   (rsp_vel_lat),
      .rsp_yaw_rate  (rsp_yaw_rate),
      .rsp_vel_valid (rsp_vel_valid),
      .rsp_saturated (rsp_saturated)
   );

endmodule

// ===== rtl/core/pdbv_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdbv_ctrl
// Sequencer: accepts a request and, when it is derived, steps the divider
// three times, the cordic and the rotation, then holds the result register handshake.
// ----------------------------------------------------------------------------
module pdbv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  pdbv_pkg::pdbv_sts_type sts,
   output pdbv_pkg::pdbv_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_DIV_LOAD,
      S_DIV_RUN,
      S_DIV_STORE,
      S_COR,
      S_MAC,
      S_DONE
   } state_type;

   state_type                    state_ff, state_in;
   pdbv_pkg::pdbv_sel_type       sel_ff, sel_in;
   logic [pdbv_pkg::CntW-1:0]    cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.div_sel  = sel_ff;
      cmd.cor_idx  = cnt_ff[4:0];
      cmd.mac_idx  = cnt_ff[2:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECIDE;
               sel_in      = pdbv_pkg::SEL_X;
            end
         end
         // derivation decision is registered at capture
         S_DECIDE: begin
            if (sts.derive) begin
               state_in = S_DIV_LOAD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV_RUN;
         end
         S_DIV_RUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == pdbv_pkg::CntW'(pdbv_pkg::DivSteps - 1)) begin
               state_in = S_DIV_STORE;
            end
         end
         S_DIV_STORE: begin
            cmd.div_store = 1'b1;
            cnt_in        = '0;
            case (sel_ff)
               pdbv_pkg::SEL_X: begin
                  sel_in   = pdbv_pkg::SEL_Y;
                  state_in = S_DIV_LOAD;
               end
               pdbv_pkg::SEL_Y: begin
                  sel_in   = pdbv_pkg::SEL_W;
                  state_in = S_DIV_LOAD;
               end
               default: begin
                  state_in = S_COR;
               end
            endcase
         end
         S_COR: begin
            cmd.cor_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == pdbv_pkg::CntW'(pdbv_pkg::CorSteps - 1)) begin
               cnt_in   = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            cmd.mac_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == pdbv_pkg::CntW'(pdbv_pkg::MacSteps - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, counter and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= pdbv_pkg::SEL_X;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/pdbv_dp.sv =====
// ----------------------------------------------------------------------------
// pdbv_dp
// Datapath: pose history, restoring divider, cordic, rotation multiplier and
// result registers.
// ----------------------------------------------------------------------------
module pdbv_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_data,
   input  logic signed [31:0]            req_pos_x,
   input  logic signed [31:0]            req_pos_y,
   input  logic signed [18:0]            req_heading,
   input  logic [47:0]                   req_time_us,
   input  logic                          req_has_vel,
   input  logic signed [31:0]            req_vx_in,
   input  logic signed [31:0]            req_vy_in,
   input  logic signed [31:0]            req_wz_in,
   input  pdbv_pkg::pdbv_cmd_type        cmd,
   output pdbv_pkg::pdbv_sts_type        sts,
   output logic signed [31:0]            rsp_vel_fwd,
   output logic signed [31:0]            rsp_vel_lat,
   output logic signed [31:0]            rsp_yaw_rate,
   output logic                          rsp_vel_valid,
   output logic                          rsp_saturated
);

   localparam int DiffW = pdbv_pkg::DiffW;
   localparam int AngW  = pdbv_pkg::AngW;
   localparam int NumW  = pdbv_pkg::NumW;
   localparam int RemW  = pdbv_pkg::RemW;
   localparam int WvW   = pdbv_pkg::WvW;
   localparam int XyW   = pdbv_pkg::XyW;
   localparam int ZW    = pdbv_pkg::ZW;
   localparam int TrigW = pdbv_pkg::TrigW;
   localparam int AccW  = pdbv_pkg::AccW;
   localparam int RndW  = pdbv_pkg::RndW;
   localparam int TimeW = pdbv_pkg::TimeW;

   // configuration and history
   logic                         enable_ff;
   logic                         last_valid_ff;
   logic signed [31:0]           last_x_ff, last_y_ff;
   logic signed [18:0]           last_head_ff;
   logic [TimeW-1:0]             last_time_ff;

   // per request operands
   logic                         derive_ff;
   logic signed [DiffW-1:0]      dx_ff, dy_ff;
   logic signed [AngW-1:0]       dyaw_ff;
   logic [TimeW-1:0]             dt_ff;

   // divider
   logic [NumW-1:0]              num_ff;
   logic [RemW-1:0]              rem_ff;
   logic                         neg_ff;

   // cordic
   logic signed [XyW-1:0]        cx_ff, cy_ff;
   logic signed [ZW-1:0]         cz_ff;
   logic                         flip_ff;

   // rotation
   logic signed [WvW-1:0]        vxw_ff, vyw_ff;
   logic signed [AccW-1:0]       prod_ff, acc_ff;

   // results
   logic signed [31:0]           res_fwd_ff, res_lat_ff, res_wz_ff;
   logic                         res_valid_ff, res_sat_ff;
   logic signed [31:0]           out_fwd_ff, out_lat_ff, out_wz_ff;
   logic                         out_valid_ff, out_sat_ff;

   // capture arithmetic
   logic signed [TimeW:0]        dt_w;
   logic signed [AngW-1:0]       dh_w, dh_unw, h0, h1, h2;
   logic                         flip_w;

   // divider arithmetic
   logic signed [DiffW-1:0]      div_src;
   logic [DiffW-1:0]             div_mag;
   logic [NumW-1:0]              div_num;
   logic [RemW-1:0]              rem_sh;
   logic                         q_bit;
   logic                         sat_pos, sat_neg;
   logic signed [NumW-1:0]       q_clip;

   // cordic and rotation arithmetic
   logic signed [XyW-1:0]        xs, ys, xt, yt;
   logic signed [ZW-1:0]         at_w;
   logic signed [TrigW-1:0]      cos_w, sin_w, m_a;
   logic signed [WvW-1:0]        m_b;
   logic signed [AccW:0]         prod_w;
   logic signed [AccW-1:0]       acc_rnd;
   logic signed [RndW-1:0]       rnd_w, rnd_clip;
   logic                         rnd_sat;

   assign sts.derive = derive_ff;

   // time gap and unwrapped heading difference
   always_comb begin
      dt_w   = $signed({1'b0, req_time_us}) - $signed({1'b0, last_time_ff});
      dh_w   = AngW'(req_heading) - AngW'(last_head_ff);
      dh_unw = dh_w;
      if (dh_w > pdbv_pkg::PI_Q16) begin
         dh_unw = dh_w - pdbv_pkg::TWO_PI_Q16;
      end else if (dh_w < -pdbv_pkg::PI_Q16) begin
         dh_unw = dh_w + pdbv_pkg::TWO_PI_Q16;
      end
      // heading into +-pi, then into +-pi/2 with a sign flip
      h0 = AngW'(req_heading);
      h1 = h0;
      if (h0 > pdbv_pkg::PI_Q16) begin
         h1 = h0 - pdbv_pkg::TWO_PI_Q16;
      end else if (h0 < -pdbv_pkg::PI_Q16) begin
         h1 = h0 + pdbv_pkg::TWO_PI_Q16;
      end
      h2     = h1;
      flip_w = 1'b0;
      if (h1 > pdbv_pkg::HALF_PI_Q16) begin
         h2     = h1 - pdbv_pkg::PI_Q16;
         flip_w = 1'b1;
      end else if (h1 < -pdbv_pkg::HALF_PI_Q16) begin
         h2     = h1 + pdbv_pkg::PI_Q16;
         flip_w = 1'b1;
      end
   end

   // divider operand, step and clip
   always_comb begin
      case (cmd.div_sel)
         pdbv_pkg::SEL_X: div_src = dx_ff;
         pdbv_pkg::SEL_Y: div_src = dy_ff;
         default:         div_src = DiffW'(dyaw_ff);
      endcase
      div_mag = div_src[DiffW-1] ? DiffW'(-div_src) : DiffW'(div_src);
      div_num = NumW'(div_mag) * NumW'(pdbv_pkg::US_PER_S);
      rem_sh  = {rem_ff[RemW-2:0], num_ff[NumW-1]};
      q_bit   = (rem_sh >= {1'b0, dt_ff});
      if (cmd.div_sel == pdbv_pkg::SEL_W) begin
         sat_pos = !neg_ff && (num_ff > pdbv_pkg::YAW_LIM - 1'b1);
         sat_neg = neg_ff && (num_ff > pdbv_pkg::YAW_LIM);
         q_clip  = sat_pos ? $signed(pdbv_pkg::YAW_LIM - 1'b1) :
                   sat_neg ? -$signed(pdbv_pkg::YAW_LIM) :
                   neg_ff  ? -$signed(num_ff) : $signed(num_ff);
      end else begin
         sat_pos = !neg_ff && (num_ff > pdbv_pkg::WV_LIM - 1'b1);
         sat_neg = neg_ff && (num_ff > pdbv_pkg::WV_LIM);
         q_clip  = sat_pos ? $signed(pdbv_pkg::WV_LIM - 1'b1) :
                   sat_neg ? -$signed(pdbv_pkg::WV_LIM) :
                   neg_ff  ? -$signed(num_ff) : $signed(num_ff);
      end
   end

   // cordic micro-rotation, trig outputs and rotation multiplier
   always_comb begin
      xs      = cx_ff >>> cmd.cor_idx;
      ys      = cy_ff >>> cmd.cor_idx;
      at_w    = pdbv_pkg::atan_q24(cmd.cor_idx);
      xt      = cx_ff >>> 10;
      yt      = cy_ff >>> 10;
      cos_w   = flip_ff ? -TrigW'(xt) : TrigW'(xt);
      sin_w   = flip_ff ? -TrigW'(yt) : TrigW'(yt);
      m_a     = (cmd.mac_idx == 3'd0 || cmd.mac_idx == 3'd2) ? cos_w : sin_w;
      m_b     = (cmd.mac_idx == 3'd0 || cmd.mac_idx == 3'd3) ? vxw_ff : vyw_ff;
      prod_w  = m_a * m_b;
      // round half up from Q.36 to Q16.16 and clip to 32 bits
      acc_rnd = acc_ff + AccW'(64'sd524288);
      rnd_w   = RndW'(acc_rnd >>> 20);
      rnd_sat = (rnd_w > pdbv_pkg::OUT_MAX) || (rnd_w < pdbv_pkg::OUT_MIN);
      rnd_clip = (rnd_w > pdbv_pkg::OUT_MAX) ? pdbv_pkg::OUT_MAX :
                 (rnd_w < pdbv_pkg::OUT_MIN) ? pdbv_pkg::OUT_MIN : rnd_w;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b1;
         last_valid_ff <= 1'b0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         last_head_ff  <= '0;
         last_time_ff  <= '0;
         derive_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            enable_ff <= csr_data;
         end
         if (cmd.capture) begin
            derive_ff     <= !req_has_vel && enable_ff && last_valid_ff &&
                             (dt_w > pdbv_pkg::MIN_DT_US);
            last_valid_ff <= 1'b1;
            last_x_ff     <= req_pos_x;
            last_y_ff     <= req_pos_y;
            last_head_ff  <= req_heading;
            last_time_ff  <= req_time_us;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      // request capture, pass-through result by default
      if (cmd.capture) begin
         dx_ff        <= DiffW'(req_pos_x) - DiffW'(last_x_ff);
         dy_ff        <= DiffW'(req_pos_y) - DiffW'(last_y_ff);
         dyaw_ff      <= dh_unw;
         dt_ff        <= dt_w[TimeW-1:0];
         cx_ff        <= pdbv_pkg::CORDIC_GAIN;
         cy_ff        <= '0;
         cz_ff        <= ZW'(h2) <<< 8;
         flip_ff      <= flip_w;
         res_fwd_ff   <= req_vx_in;
         res_lat_ff   <= req_vy_in;
         res_wz_ff    <= req_wz_in;
         res_valid_ff <= req_has_vel;
         res_sat_ff   <= 1'b0;
      end
      // divider
      if (cmd.div_load) begin
         num_ff <= div_num;
         rem_ff <= '0;
         neg_ff <= div_src[DiffW-1];
      end
      if (cmd.div_step) begin
         rem_ff <= q_bit ? (rem_sh - {1'b0, dt_ff}) : rem_sh;
         num_ff <= {num_ff[NumW-2:0], q_bit};
      end
      if (cmd.div_store) begin
         case (cmd.div_sel)
            pdbv_pkg::SEL_X: vxw_ff    <= q_clip[WvW-1:0];
            pdbv_pkg::SEL_Y: vyw_ff    <= q_clip[WvW-1:0];
            default:         res_wz_ff <= q_clip[31:0];
         endcase
         res_valid_ff <= 1'b1;
         if (sat_pos || sat_neg) begin
            res_sat_ff <= 1'b1;
         end
      end
      // cordic
      if (cmd.cor_step) begin
         if (!cz_ff[ZW-1]) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - at_w;
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + at_w;
         end
      end
      // rotation: products one a cycle, sums and rounding after
      if (cmd.mac_step) begin
         prod_ff <= prod_w[AccW-1:0];
         case (cmd.mac_idx)
            3'd1: acc_ff <= prod_ff;
            3'd2: acc_ff <= acc_ff + prod_ff;
            3'd3: begin
               res_fwd_ff <= rnd_clip[31:0];
               acc_ff     <= prod_ff;
               if (rnd_sat) begin
                  res_sat_ff <= 1'b1;
               end
            end
            3'd4: acc_ff <= acc_ff - prod_ff;
            3'd5: begin
               res_lat_ff <= rnd_clip[31:0];
               if (rnd_sat) begin
                  res_sat_ff <= 1'b1;
               end
            end
            default: acc_ff <= acc_ff;
         endcase
      end
      // response register
      if (cmd.out_load) begin
         out_fwd_ff   <= res_fwd_ff;
         out_lat_ff   <= res_lat_ff;
         out_wz_ff    <= res_wz_ff;
         out_valid_ff <= res_valid_ff;
         out_sat_ff   <= res_sat_ff;
      end
   end

   assign rsp_vel_fwd   = out_fwd_ff;
   assign rsp_vel_lat   = out_lat_ff;
   assign rsp_yaw_rate  = out_wz_ff;
   assign rsp_vel_valid = out_valid_ff;
   assign rsp_saturated = out_sat_ff;

endmodule
